[rtl/core/cbd_pkg.sv]
`default_nettype none
package cbd_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int TRAILER_LEN   = 2;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_SP = 8'h20;

  typedef enum logic [2:0] {
    MODE_LEAD,
    MODE_DIGITS,
    MODE_REST,
    MODE_DATA,
    MODE_TRAILER
  } mode_t;

  typedef enum logic [1:0] {
    END_ZERO_CHUNK,
    END_OUTSIDE,
    END_MID_CHUNK,
    END_OVERFLOW
  } end_status_t;

  // bit 4: is a hex digit, bits 3:0: its value
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, 4'(b - "0")};
    end else if (b >= "a" && b <= "f") begin
      r = {1'b1, 4'(b - "a" + 8'd10)};
    end else if (b >= "A" && b <= "F") begin
      r = {1'b1, 4'(b - "A" + 8'd10)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/chunked_body_decoder_core.sv]
// channel  dir  tdata                tuser                               tlast
// s_axis   in   [7:0] in_byte        -                                   in_last
// m_axis   out  [7:0] out_byte       [0] byte_valid, [2:1] end_status    end_of_body
//
// One byte per cycle sustained while results are taken; each byte passes the input, then the result register.
// Input register feeds one pass of parse logic that loads the result register.
// A byte that yields no result still updates the parser and leaves no output.
// rst is synchronous and returns the parser to awaiting a size line.
// s_axis_tready drops only while both the input and result registers are held.
`default_nettype none
module chunked_body_decoder_core
  import cbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]      m_axis_tuser,   // [0] byte_valid, [2:1] end_status
  output logic            m_axis_tlast
);

  localparam logic [1:0] TRAILER_INIT = 2'(TRAILER_LEN);

  logic       in_v;
  logic [7:0] in_b;
  logic       in_l;

  mode_t                mode, mode_next, mode_upd;
  logic [SIZE_BITS-1:0] remaining, remaining_next, remaining_upd, remaining_dec;
  logic                 digit_seen, digit_seen_next, digit_seen_upd;
  logic                 prev_cr, prev_cr_next, prev_cr_upd;
  logic [1:0]           trailer_skip, trailer_skip_next, trailer_skip_upd, skip_dec;
  logic                 finished, finished_next, finished_upd;

  logic        step_valid, step_end;
  end_status_t step_status;
  logic        res_emit, res_end;
  end_status_t res_status;
  logic [4:0]  hex;

  logic out_free, proc;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign proc          = in_v && out_free;
  assign s_axis_tready = !in_v || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v <= 1'b1;
    end else if (proc) begin
      in_v <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_b <= s_axis_tdata;
      in_l <= s_axis_tlast;
    end
  end

  assign hex           = hex_decode(in_b);
  assign remaining_dec = remaining - SIZE_BITS'(1);
  assign skip_dec      = (trailer_skip != 2'd0) ? trailer_skip - 2'd1 : 2'd0;

  // parse step for one byte
  always_comb begin
    mode_upd         = mode;
    remaining_upd    = remaining;
    digit_seen_upd   = digit_seen;
    prev_cr_upd      = prev_cr;
    trailer_skip_upd = trailer_skip;
    finished_upd     = finished;
    step_valid       = 1'b0;
    step_end         = 1'b0;
    step_status      = END_ZERO_CHUNK;
    if (!finished) begin
      if (mode == MODE_DATA) begin
        step_valid    = 1'b1;
        remaining_upd = remaining_dec;
        if (remaining_dec == '0) begin
          mode_upd         = MODE_TRAILER;
          trailer_skip_upd = TRAILER_INIT;
        end
      end else if (mode == MODE_TRAILER) begin
        trailer_skip_upd = skip_dec;
        if (skip_dec == 2'd0) begin
          mode_upd       = MODE_LEAD;
          remaining_upd  = '0;
          digit_seen_upd = 1'b0;
          prev_cr_upd    = 1'b0;
        end
      end else if (prev_cr && in_b == BYTE_LF) begin
        prev_cr_upd    = 1'b0;
        digit_seen_upd = 1'b0;
        if (!digit_seen || remaining == '0) begin
          step_end     = 1'b1;
          step_status  = END_ZERO_CHUNK;
          finished_upd = 1'b1;
        end else begin
          mode_upd = MODE_DATA;
        end
      end else begin
        prev_cr_upd = (in_b == BYTE_CR);
        if (mode == MODE_LEAD && in_b == BYTE_SP) begin
          mode_upd = MODE_LEAD;
        end else if (mode != MODE_REST && hex[4]) begin
          if (remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
            remaining_upd = '1;
            step_end      = 1'b1;
            step_status   = END_OVERFLOW;
            finished_upd  = 1'b1;
          end else begin
            remaining_upd  = {remaining[SIZE_BITS-5:0], hex[3:0]};
            digit_seen_upd = 1'b1;
            mode_upd       = MODE_DIGITS;
          end
        end else begin
          mode_upd = MODE_REST;
        end
      end
    end
  end

  // close at end of body, return to reset state after in_last
  always_comb begin
    res_end    = step_end;
    res_status = step_status;
    if (in_l && !step_end && !finished_upd) begin
      res_end    = 1'b1;
      res_status = (mode_upd == MODE_DATA) ? END_MID_CHUNK : END_OUTSIDE;
    end
    res_emit = step_valid || res_end;
    if (in_l) begin
      mode_next         = MODE_LEAD;
      remaining_next    = '0;
      digit_seen_next   = 1'b0;
      prev_cr_next      = 1'b0;
      trailer_skip_next = 2'd0;
      finished_next     = 1'b0;
    end else begin
      mode_next         = mode_upd;
      remaining_next    = remaining_upd;
      digit_seen_next   = digit_seen_upd;
      prev_cr_next      = prev_cr_upd;
      trailer_skip_next = trailer_skip_upd;
      finished_next     = finished_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_LEAD;
      remaining    <= '0;
      digit_seen   <= 1'b0;
      prev_cr      <= 1'b0;
      trailer_skip <= 2'd0;
      finished     <= 1'b0;
    end else if (proc) begin
      mode         <= mode_next;
      remaining    <= remaining_next;
      digit_seen   <= digit_seen_next;
      prev_cr      <= prev_cr_next;
      trailer_skip <= trailer_skip_next;
      finished     <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc && res_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (proc && res_emit) begin
      m_axis_tdata <= step_valid ? in_b : 8'd0;
      m_axis_tuser <= {res_end ? res_status : END_ZERO_CHUNK, step_valid};
      m_axis_tlast <= res_end;
    end
  end

endmodule
`default_nettype wire

[rtl/core/cbd_checker.sv]
`default_nettype none
module cbd_checker
  import cbd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("input changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_empty_closes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("result without payload byte does not close the body");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:1] == END_ZERO_CHUNK)
    else $error("end status set on a non-closing result");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
    else $error("data nonzero without payload byte");

endmodule

bind chunked_body_decoder_core cbd_checker u_cbd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
